// ----- src/rss_pkg.sv -----
package rss_pkg;

  // Fixed field widths of the request and response items and of the notch mask.
  localparam int LETTER_W = 5;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int NOTCH_W  = 26;

  // Default alphabet size.
  localparam int ALPHABET_DEF = 26;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_FORWARD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CHECK   = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_MAP   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [LETTER_W-1:0] entry_index;
    logic [LETTER_W-1:0] letter;
  } req_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic                notch_hit;
    logic [STATUS_W-1:0] status;
    logic [LETTER_W-1:0] position;
  } rsp_t;

endpackage

// ----- src/rss_table.sv -----
// Substitution table: one write port and one registered read port. A write
// to the entry that is read in the same cycle is forwarded to the read data.
// The read data holds while no read is issued.
module rss_table #(
  parameter int DEPTH = rss_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [rss_pkg::LETTER_W-1:0]  wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [rss_pkg::LETTER_W-1:0]  rdata
);
  import rss_pkg::*;

  logic [LETTER_W-1:0] mem [DEPTH];
  logic [LETTER_W-1:0] mem_q;
  logic [LETTER_W-1:0] fwd_data;
  logic                fwd_hit;

  // Storage write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read with capture of a colliding write.
  always_ff @(posedge clk) begin
    if (re) begin
      mem_q    <= mem[raddr];
      fwd_hit  <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd_hit ? fwd_data : mem_q;

endmodule

// ----- src/rotor_substitution_stepper.sv -----
// One cipher rotor over an alphabet of ALPHABET letters. The wiring and its
// inverse live in two small synchronous tables; a request is accepted every
// cycle unless the response stalls, and goes through the table read, then
// the check and result register. This rate is set by the single read port
// of each table: a cipher request reads one entry of each table and uses
// one, a load request reads the old wiring entry to free its letter and
// writes both tables when the response is formed. The rotor position is
// updated at acceptance, so step and assign requests take effect for the
// very next request. Configuration (start position and notch mask) may be
// written only while the rotor holds no request.
module rotor_substitution_stepper #(
  parameter int ALPHABET = rss_pkg::ALPHABET_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  rss_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output rss_pkg::rsp_t                rsp,
  input  logic                         cfg_wen,
  input  logic [0:0]                   cfg_idx,
  input  logic [rss_pkg::NOTCH_W-1:0]  cfg_wdata
);
  import rss_pkg::*;

  localparam int AW = $clog2(ALPHABET);
  localparam logic [LETTER_W:0]   A_EXT    = (LETTER_W+1)'(ALPHABET);
  localparam logic [LETTER_W-1:0] POS_LAST = LETTER_W'(ALPHABET - 1);
  localparam logic [0:0] CFG_START = 1'b0;
  localparam logic [0:0] CFG_NOTCH = 1'b1;

  // Configuration registers.
  logic [LETTER_W-1:0] start_position;
  logic [NOTCH_W-1:0]  notch_mask;

  // Rotor state.
  logic [LETTER_W-1:0] pos;
  logic [LETTER_W-1:0] pos_next;
  logic [ALPHABET-1:0] used;
  logic [ALPHABET-1:0] written;

  // Second stage.
  logic                s1_valid;
  logic [FUNC_W-1:0]   s1_func;
  logic [LETTER_W-1:0] s1_idx;
  logic [LETTER_W-1:0] s1_let;
  logic [LETTER_W-1:0] s1_pos;
  logic                s1_adv;

  logic                accept;
  logic [LETTER_W:0]   cipher_sum;
  logic [LETTER_W:0]   cipher_wrap;
  logic [AW-1:0]       cipher_addr;
  logic [AW-1:0]       wiring_raddr;

  logic [LETTER_W-1:0] wiring_q;
  logic [LETTER_W-1:0] inverse_q;

  logic                complete;
  logic                let_bad;
  logic                idx_bad;
  logic [ALPHABET-1:0] freed;
  logic                load_ok;
  logic [LETTER_W-1:0] cipher_v;
  logic [LETTER_W:0]   diff_direct;
  logic [LETTER_W:0]   diff_wrap;
  logic [31:0]         notch_ext;
  rsp_t                rsp_next;

  // Request handshake: the second stage moves on whenever the response
  // register is empty or being taken. Nothing is taken during reset.
  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = rst || (s1_valid && !s1_adv);
  assign accept    = req_valid && !req_stall;

  // Position update at acceptance.
  always_comb begin
    pos_next = pos;
    case (req.func)
      FUNC_STEP: begin
        pos_next = (pos == POS_LAST) ? '0 : pos + 1'b1;
      end
      FUNC_ASSIGN: begin
        if ({1'b0, start_position} < A_EXT) begin
          pos_next = start_position;
        end
      end
      default: begin
        pos_next = pos;
      end
    endcase
  end

  // Cipher table address: (letter + position) mod ALPHABET.
  assign cipher_sum   = {1'b0, req.letter} + {1'b0, pos};
  assign cipher_wrap  = (cipher_sum >= A_EXT) ? cipher_sum - A_EXT : cipher_sum;
  assign cipher_addr  = cipher_wrap[AW-1:0];
  assign wiring_raddr = (req.func == FUNC_LOAD) ? req.entry_index[AW-1:0] : cipher_addr;

  // Stage two checks.
  assign complete = &used;
  assign let_bad  = {1'b0, s1_let} >= A_EXT;
  assign idx_bad  = {1'b0, s1_idx} >= A_EXT;

  // A rewritten entry first releases its previous letter.
  always_comb begin
    freed = used;
    if (written[s1_idx[AW-1:0]]) begin
      freed = used & ~(ALPHABET'(1) << wiring_q[AW-1:0]);
    end
  end

  assign load_ok = s1_adv && (s1_func == FUNC_LOAD) && !let_bad && !idx_bad
                   && !freed[s1_let[AW-1:0]];

  // Cipher output: (table value - position) mod ALPHABET.
  assign cipher_v    = (s1_func == FUNC_FORWARD) ? wiring_q : inverse_q;
  assign diff_direct = {1'b0, cipher_v} - {1'b0, s1_pos};
  assign diff_wrap   = {1'b0, cipher_v} + A_EXT - {1'b0, s1_pos};
  assign notch_ext   = {{(32-NOTCH_W){1'b0}}, notch_mask};

  // Response formation.
  always_comb begin
    rsp_next            = '0;
    rsp_next.position   = s1_pos;
    rsp_next.notch_hit  = notch_ext[s1_pos];
    rsp_next.status     = STATUS_OK;
    case (s1_func)
      FUNC_FORWARD, FUNC_REVERSE: begin
        if (let_bad) begin
          rsp_next.status = STATUS_BAD_INDEX;
        end else if (!complete) begin
          rsp_next.status = STATUS_BAD_MAP;
        end else if (cipher_v >= s1_pos) begin
          rsp_next.out_letter = diff_direct[LETTER_W-1:0];
        end else begin
          rsp_next.out_letter = diff_wrap[LETTER_W-1:0];
        end
      end
      FUNC_STEP: begin
        rsp_next.status = STATUS_OK;
      end
      FUNC_LOAD: begin
        if (let_bad || idx_bad) begin
          rsp_next.status = STATUS_BAD_INDEX;
        end else if (freed[s1_let[AW-1:0]]) begin
          rsp_next.status = STATUS_BAD_MAP;
        end
      end
      FUNC_ASSIGN: begin
        if ({1'b0, start_position} >= A_EXT) begin
          rsp_next.status = STATUS_BAD_INDEX;
        end
      end
      FUNC_CHECK: begin
        rsp_next.status = complete ? STATUS_OK : STATUS_BAD_MAP;
      end
      default: begin
        rsp_next.status = STATUS_BAD_INDEX;
      end
    endcase
  end

  // Wiring table: written at the entry index, read at the entry index for a
  // load and at the cipher address otherwise.
  rss_table #(
    .DEPTH (ALPHABET)
  ) u_wiring (
    .clk   (clk),
    .we    (load_ok),
    .waddr (s1_idx[AW-1:0]),
    .wdata (s1_let),
    .re    (accept),
    .raddr (wiring_raddr),
    .rdata (wiring_q)
  );

  // Inverse table: written at the letter, read at the cipher address.
  rss_table #(
    .DEPTH (ALPHABET)
  ) u_inverse (
    .clk   (clk),
    .we    (load_ok),
    .waddr (s1_let[AW-1:0]),
    .wdata (s1_idx),
    .re    (accept),
    .raddr (cipher_addr),
    .rdata (inverse_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      notch_mask     <= '0;
    end else if (cfg_wen) begin
      case (cfg_idx)
        CFG_START: start_position <= cfg_wdata[LETTER_W-1:0];
        CFG_NOTCH: notch_mask     <= cfg_wdata;
        default:   notch_mask     <= notch_mask;
      endcase
    end
  end

  // Position and wiring bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      used    <= '0;
      written <= '0;
    end else begin
      if (accept) begin
        pos <= pos_next;
      end
      if (load_ok) begin
        used                    <= freed | (ALPHABET'(1) << s1_let[AW-1:0]);
        written[s1_idx[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Second stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= req.func;
      s1_idx  <= req.entry_index;
      s1_let  <= req.letter;
      s1_pos  <= pos_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

endmodule
